/* rtl/core/trace_driven_link_release_assert.svh */
// Assertion macros for the trace driven link release block.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef TRACE_DRIVEN_LINK_RELEASE_ASSERT_SVH
`define TRACE_DRIVEN_LINK_RELEASE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TDLR_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("tdlr assertion failed");

// Next-cycle implication, checked outside reset.
`define TDLR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("tdlr assertion failed");

`endif

/* rtl/core/tdlr_pkg.sv */
// Shared types and constants for the trace driven link release block.
// No dependencies; the front end, back end and top level refer to it by scoped names.
`timescale 1ns / 1ps

package tdlr_pkg;

  localparam int TRACE_DEPTH_DEFAULT = 4096;
  localparam int TIME_BITS_DEFAULT   = 32;
  localparam int CMD_QUEUE_DEPTH     = 2;
  localparam int RES_QUEUE_DEPTH     = 2;

  localparam int LEN_W       = 13;
  localparam int CFG_INDEX_W = 1;

  localparam logic [LEN_W-1:0] COUNT_MAX = 13'h1FFF;

  // Input mode codes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WR_FWD = 2'd1;
  localparam logic [1:0] MODE_WR_REV = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WR_FWD  = 2'd1,
    CMD_WR_REV  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] entry_index;
    logic [31:0] entry_time;
    logic [15:0] forward_waiting;
    logic [15:0] reverse_waiting;
  } in_item_t;

  typedef struct packed {
    logic [12:0] forward_opportunities;
    logic [12:0] reverse_opportunities;
    logic [12:0] forward_released;
    logic [12:0] reverse_released;
    logic        restarted;
    logic        active;
  } out_item_t;

  // Classified command handed from front to back; nop marks an unknown mode
  typedef struct packed {
    cmd_op_t     op;
    logic        nop;
    logic [11:0] entry_index;
    logic [31:0] entry_time;
    logic [15:0] forward_waiting;
    logic [15:0] reverse_waiting;
  } cmd_t;

endpackage

/* rtl/core/tdlr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tdlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tdlr_fifo.sv */
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps

module tdlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/tdlr_front.sv */
// Front end: accepts input beats, classifies them into commands, queues them.
// Depends on tdlr_pkg and tdlr_fifo.
`timescale 1ns / 1ps

module tdlr_front #(
  parameter int TRACE_DEPTH = tdlr_pkg::TRACE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tdlr_pkg::in_item_t item,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output tdlr_pkg::cmd_t     cmd
);

  tdlr_pkg::cmd_t            cmd_in;
  logic                      in_range;
  logic                      cmd_empty;
  logic [$bits(tdlr_pkg::cmd_t)-1:0] cmd_rdata;

  assign in_range = (32'(item.entry_index) < 32'(TRACE_DEPTH));

  always_comb begin
    cmd_in.nop             = 1'b0;
    cmd_in.entry_index     = item.entry_index;
    cmd_in.entry_time      = item.entry_time;
    cmd_in.forward_waiting = item.forward_waiting;
    cmd_in.reverse_waiting = item.reverse_waiting;
    unique case (item.mode)
      tdlr_pkg::MODE_TICK:   cmd_in.op = tdlr_pkg::CMD_TICK;
      tdlr_pkg::MODE_WR_FWD: cmd_in.op = in_range ? tdlr_pkg::CMD_WR_FWD : tdlr_pkg::CMD_RESTART;
      tdlr_pkg::MODE_WR_REV: cmd_in.op = in_range ? tdlr_pkg::CMD_WR_REV : tdlr_pkg::CMD_RESTART;
      default: begin
        cmd_in.op  = tdlr_pkg::CMD_TICK;
        cmd_in.nop = 1'b1;
      end
    endcase
  end

  tdlr_fifo #(
    .WIDTH ($bits(tdlr_pkg::cmd_t)),
    .DEPTH (tdlr_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = tdlr_pkg::cmd_t'(cmd_rdata);

endmodule

/* rtl/core/tdlr_back.sv */
// Back end: trace tables, schedule state and the walk sequencer.
// Depends on tdlr_pkg and tdlr_ram.
`timescale 1ns / 1ps

module tdlr_back #(
  parameter int TRACE_DEPTH = tdlr_pkg::TRACE_DEPTH_DEFAULT,
  parameter int TIME_BITS   = tdlr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tdlr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tdlr_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_pop,
  input  tdlr_pkg::cmd_t                      cmd,
  input  logic                                res_full,
  output logic                                res_push,
  output tdlr_pkg::out_item_t                 res
);

  localparam int ADDR_W = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int POS_W  = $clog2(TRACE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [tdlr_pkg::LEN_W-1:0] f_length, r_length;
  logic [POS_W-1:0]           f_len, r_len;
  logic [POS_W-1:0]           f_pos, r_pos;
  logic [TIME_BITS-1:0]       elapsed;
  logic [TIME_BITS-1:0]       f_rdata, r_rdata;
  logic [tdlr_pkg::LEN_W-1:0] f_cnt, r_cnt;
  logic [15:0]                f_wait, r_wait;
  logic                       f_done, r_done;
  logic                       second, restarted;
  logic                       active;
  logic                       f_hit, r_hit, f_adv, r_adv, loop_hit;
  logic                       f_we, r_we;

  // Lengths beyond the table depth act as the depth
  assign f_len = (32'(f_length) > 32'(TRACE_DEPTH)) ? POS_W'(TRACE_DEPTH) : POS_W'(f_length);
  assign r_len = (32'(r_length) > 32'(TRACE_DEPTH)) ? POS_W'(TRACE_DEPTH) : POS_W'(r_length);
  assign active = (f_length != '0) && (r_length != '0);

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign f_we    = cmd_pop && !cmd.nop && (cmd.op == tdlr_pkg::CMD_WR_FWD);
  assign r_we    = cmd_pop && !cmd.nop && (cmd.op == tdlr_pkg::CMD_WR_REV);

  tdlr_ram #(.WIDTH(TIME_BITS), .DEPTH(TRACE_DEPTH)) u_fwd_table (
    .clk   (clk),
    .we    (f_we),
    .waddr (ADDR_W'(cmd.entry_index)),
    .wdata (TIME_BITS'(cmd.entry_time)),
    .raddr (f_pos[ADDR_W-1:0]),
    .rdata (f_rdata)
  );

  tdlr_ram #(.WIDTH(TIME_BITS), .DEPTH(TRACE_DEPTH)) u_rev_table (
    .clk   (clk),
    .we    (r_we),
    .waddr (ADDR_W'(cmd.entry_index)),
    .wdata (TIME_BITS'(cmd.entry_time)),
    .raddr (r_pos[ADDR_W-1:0]),
    .rdata (r_rdata)
  );

  assign f_hit    = (f_pos < f_len) && (f_rdata <= elapsed);
  assign r_hit    = (r_pos < r_len) && (r_rdata <= elapsed);
  assign f_adv    = !f_done && f_hit;
  assign r_adv    = !r_done && r_hit;
  assign loop_hit = !second && (f_pos >= f_len) && (r_pos >= r_len);

  assign res_push = (state == ST_DONE) && !res_full;

  always_comb begin
    res.forward_opportunities = f_cnt;
    res.reverse_opportunities = r_cnt;
    res.forward_released      = ({3'b000, f_cnt} < f_wait) ? f_cnt : f_wait[12:0];
    res.reverse_released      = ({3'b000, r_cnt} < r_wait) ? r_cnt : r_wait[12:0];
    res.restarted             = restarted;
    res.active                = active;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (!cmd.nop && cmd.op == tdlr_pkg::CMD_TICK && active) ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (f_adv || r_adv || loop_hit) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      f_wait <= cmd.forward_waiting;
      r_wait <= cmd.reverse_waiting;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      f_length  <= '0;
      r_length  <= '0;
      f_pos     <= '0;
      r_pos     <= '0;
      elapsed   <= '0;
      f_cnt     <= '0;
      r_cnt     <= '0;
      f_done    <= 1'b0;
      r_done    <= 1'b0;
      second    <= 1'b0;
      restarted <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            f_cnt     <= '0;
            r_cnt     <= '0;
            f_done    <= 1'b0;
            r_done    <= 1'b0;
            second    <= 1'b0;
            restarted <= 1'b0;
            if (!cmd.nop) begin
              case (cmd.op)
                tdlr_pkg::CMD_TICK: begin
                  if (active && elapsed != '1) begin
                    elapsed <= elapsed + 1'b1;
                  end
                end
                default: begin
                  f_pos   <= '0;
                  r_pos   <= '0;
                  elapsed <= '0;
                end
              endcase
            end
          end
        end
        ST_READ: begin
        end
        ST_CMP: begin
          if (!f_adv && !r_adv && loop_hit) begin
            // Both tables used up: loop once and walk time-zero entries again
            f_pos     <= '0;
            r_pos     <= '0;
            elapsed   <= '0;
            f_done    <= 1'b0;
            r_done    <= 1'b0;
            second    <= 1'b1;
            restarted <= 1'b1;
          end else begin
            // Advance each direction over one reached entry, or mark it done
            if (f_adv) begin
              f_pos <= f_pos + 1'b1;
              if (f_cnt != tdlr_pkg::COUNT_MAX) begin
                f_cnt <= f_cnt + 1'b1;
              end
            end else begin
              f_done <= 1'b1;
            end
            if (r_adv) begin
              r_pos <= r_pos + 1'b1;
              if (r_cnt != tdlr_pkg::COUNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
              end
            end else begin
              r_done <= 1'b1;
            end
          end
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          tdlr_pkg::REG_FORWARD_LENGTH: f_length <= cfg_data;
          tdlr_pkg::REG_REVERSE_LENGTH: r_length <= cfg_data;
          default: begin
          end
        endcase
        f_pos   <= '0;
        r_pos   <= '0;
        elapsed <= '0;
      end
    end
  end

endmodule

/* rtl/core/trace_driven_link_release.sv */
// Top level of the trace driven link release block.
// Depends on tdlr_pkg, tdlr_front, tdlr_back, tdlr_fifo and the assertion header.
`timescale 1ns / 1ps
`include "trace_driven_link_release_assert.svh"

// Trace driven two-direction link release scheduler.
// Input channel: push/full with one item beat; a beat is taken when push is high and
// full is low. A tick beat advances time one millisecond when active and reports how many
// trace entries each direction reached and how many waiting packets that releases; write
// beats store a timestamp at an in-range index and restart the schedule. Every input beat
// yields one result beat. Result channel: result holds the oldest result while empty is
// low; pop takes it. Configuration: cfg_we writes cfg_data into the length register picked
// by cfg_index (0 forward, 1 reverse) and restarts the schedule; write only while the block is idle.
// The back end works on one command at a time. Write and idle beats pass from queue head
// through the done state to the result queue. A tick walks the read and compare states in
// turn, since each table step is one RAM read and one compare, then reaches the done state;
// a loop restart walks the read and compare states again for the time-zero entries.
// A two-entry command queue keeps taking beats while the back end walks.
// Reset clears lengths, positions and elapsed time; table contents are not cleared.
// When the receiver stalls the result queue fills, the back end holds its finished
// result, and full rises once the command queue is also full.

module trace_driven_link_release #(
  parameter int TRACE_DEPTH = tdlr_pkg::TRACE_DEPTH_DEFAULT,
  parameter int TIME_BITS   = tdlr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  tdlr_pkg::in_item_t               item,
  output logic                             empty,
  input  logic                             pop,
  output tdlr_pkg::out_item_t              result,
  input  logic                             cfg_we,
  input  logic [tdlr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tdlr_pkg::LEN_W-1:0]       cfg_data
);

  logic                 cmd_valid;
  logic                 cmd_pop;
  tdlr_pkg::cmd_t       cmd;
  logic                 res_full;
  logic                 res_push;
  tdlr_pkg::out_item_t  res;
  logic [$bits(tdlr_pkg::out_item_t)-1:0] res_rdata;

  // Accept and classify input beats, queue them as commands
  tdlr_front #(
    .TRACE_DEPTH (TRACE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Hold the tables and walk them one command at a time
  tdlr_back #(
    .TRACE_DEPTH (TRACE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Decouple finished results from the receiver
  tdlr_fifo #(
    .WIDTH ($bits(tdlr_pkg::out_item_t)),
    .DEPTH (tdlr_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = tdlr_pkg::out_item_t'(res_rdata);

  // A loop can only happen while the schedule runs
  `TDLR_ASSERT_IMP(a_restart_needs_active, !empty && result.restarted, result.active)
  // Released packets never exceed opportunities
  `TDLR_ASSERT_IMP(a_fwd_release_bound, !empty,
                   result.forward_released <= result.forward_opportunities)
  `TDLR_ASSERT_IMP(a_rev_release_bound, !empty,
                   result.reverse_released <= result.reverse_opportunities)
  // An idle schedule reports no activity at all
  `TDLR_ASSERT_IMP(a_idle_quiet, !empty && !result.active,
                   result.forward_opportunities == '0 &&
                   result.reverse_opportunities == '0 && !result.restarted)

endmodule
